// ----- hw/rtl/pwl_pkg.sv -----
`default_nettype none

package pwl_pkg;

    // Number of wheel slots the machine can carry
    localparam int unsigned WHEEL_SLOTS = 6;

    // Widths of the fixed fields
    localparam int unsigned LETTER_W = 5;
    localparam int unsigned SUM_W    = 8;
    localparam int unsigned POS_W    = 5;
    localparam int unsigned LUG_W    = 5;
    localparam int unsigned PIN_W    = 26;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 30;

    localparam logic [LETTER_W-1:0] ALPHA = 5'd26;

    // Pin count of each wheel, wheel zero first
    localparam int unsigned WHEEL_PINS [WHEEL_SLOTS] = '{26, 25, 23, 21, 19, 17};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PIN_MASK_0      = 3'd0,
        REG_PIN_MASK_1      = 3'd1,
        REG_PIN_MASK_2      = 3'd2,
        REG_PIN_MASK_3      = 3'd3,
        REG_PIN_MASK_4      = 3'd4,
        REG_PIN_MASK_5      = 3'd5,
        REG_LUG_COUNTS      = 3'd6,
        REG_START_POSITIONS = 3'd7
    } t_cfg_reg;

    localparam t_cfg_reg PIN_MASK_REG [WHEEL_SLOTS] = '{
        REG_PIN_MASK_0, REG_PIN_MASK_1, REG_PIN_MASK_2,
        REG_PIN_MASK_3, REG_PIN_MASK_4, REG_PIN_MASK_5
    };

    // One letter travelling down the chain of wheel cells
    typedef struct packed {
        logic [LETTER_W-1:0] letter;
        logic                restart;
        logic [SUM_W-1:0]    sum;
    } t_beat;

endpackage

`default_nettype wire

// ----- hw/rtl/pin_wheel_lug_cipher_core.sv -----
// Pin-wheel lug cipher core.
//
// Input channel: i_valid / o_stall carry one beat per letter (i_letter,
// i_restart). A beat is taken at a rising edge with i_valid high and o_stall
// low. i_restart set reloads every wheel from the start register before
// that letter is enciphered.
// Output channel: o_valid / i_stall carry one beat per letter: cipher letter,
// keystream sum and key letter, in input order.
// Configuration: i_cfg_valid / o_cfg_ready with i_cfg_index and i_cfg_data;
// o_cfg_ready is always high. Write only while no letter is in flight.
// Each beat is registered once in each wheel cell and once in the mod-26 fold
// and output register on its way from input beat to output beat.
// Throughput is one letter per cycle while the receiver does not stall.
// When the receiver stalls, the output beat holds and the chain keeps filling
// its empty cells; o_stall rises only once every cell holds a letter.
// Reset clears the key registers, wheel positions and the chain valids at
// once; letter data left in the chain is dropped.
`default_nettype none

module pin_wheel_lug_cipher_core #(
    parameter int unsigned NUM_WHEELS = 6
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // letter channel
    input  wire logic                            i_valid,
    output logic                                 o_stall,
    input  wire logic [pwl_pkg::LETTER_W-1:0]    i_letter,
    input  wire logic                            i_restart,
    // result channel
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output logic [pwl_pkg::LETTER_W-1:0]         o_cipher_letter,
    output logic [pwl_pkg::SUM_W-1:0]            o_keystream_sum,
    output logic [pwl_pkg::LETTER_W-1:0]         o_key_letter,
    // configuration write channel
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [pwl_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [pwl_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import pwl_pkg::*;

    logic                 cfg_we;
    logic [PIN_W-1:0]     r_pin_mask [NUM_WHEELS];
    logic [CFG_DATA_W-1:0] r_lug_counts;
    logic [CFG_DATA_W-1:0] r_start_positions;

    // chain plumbing: slot k feeds cell k, slot NUM_WHEELS feeds the fold
    logic                 chain_valid [NUM_WHEELS+1];
    logic                 chain_ready [NUM_WHEELS+1];
    t_beat                chain_beat  [NUM_WHEELS+1];

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lug_counts      <= '0;
            r_start_positions <= '0;
        end else if (cfg_we) begin
            if (i_cfg_index == REG_LUG_COUNTS) begin
                r_lug_counts <= i_cfg_data;
            end
            if (i_cfg_index == REG_START_POSITIONS) begin
                r_start_positions <= i_cfg_data;
            end
        end
    end

    // head of the chain: a fresh letter starts with an empty sum
    assign chain_valid[0]         = i_valid;
    assign chain_beat[0].letter   = i_letter;
    assign chain_beat[0].restart  = i_restart;
    assign chain_beat[0].sum      = '0;
    assign o_stall                = !chain_ready[0];

    for (genvar k = 0; k < NUM_WHEELS; k++) begin : g_wheel
        // pin masks wider than the wheel are harmless: only in-range
        // positions are ever looked up
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_pin_mask[k] <= '0;
            end else if (cfg_we && (i_cfg_index == PIN_MASK_REG[k])) begin
                r_pin_mask[k] <= i_cfg_data[PIN_W-1:0];
            end
        end

        pwl_cell #(
            .SIZE (WHEEL_PINS[k])
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_pin_mask (r_pin_mask[k]),
            .i_lug      (r_lug_counts[LUG_W*k +: LUG_W]),
            .i_start    (r_start_positions[POS_W*k +: POS_W]),
            .i_up_valid (chain_valid[k]),
            .i_up       (chain_beat[k]),
            .o_up_ready (chain_ready[k]),
            .o_dn_valid (chain_valid[k+1]),
            .o_dn       (chain_beat[k+1]),
            .i_dn_ready (chain_ready[k+1])
        );
    end

    // tail: reduce mod 26, form the cipher letter, hold the output beat
    pwl_fold u_fold (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (chain_valid[NUM_WHEELS]),
        .i_beat          (chain_beat[NUM_WHEELS]),
        .o_ready         (chain_ready[NUM_WHEELS]),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_cipher_letter (o_cipher_letter),
        .o_keystream_sum (o_keystream_sum),
        .o_key_letter    (o_key_letter)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/pwl_cell.sv -----
`default_nettype none

module pwl_cell #(
    parameter int unsigned SIZE = 26
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic [pwl_pkg::PIN_W-1:0]   i_pin_mask,
    input  wire logic [pwl_pkg::LUG_W-1:0]   i_lug,
    input  wire logic [pwl_pkg::POS_W-1:0]   i_start,
    input  wire logic                        i_up_valid,
    input  pwl_pkg::t_beat                   i_up,
    output logic                             o_up_ready,
    output logic                             o_dn_valid,
    output pwl_pkg::t_beat                   o_dn,
    input  wire logic                        i_dn_ready
);
    import pwl_pkg::*;

    localparam logic [POS_W-1:0] SZ   = POS_W'(SIZE);
    localparam logic [POS_W-1:0] LAST = POS_W'(SIZE - 1);

    logic              r_valid;
    logic [POS_W-1:0]  r_pos;
    t_beat             r_beat;

    logic [POS_W-1:0]  start_red;
    logic [POS_W-1:0]  pos;
    logic [POS_W-1:0]  n_pos;
    t_beat             n_beat;
    logic              take;

    assign o_up_ready = !r_valid || i_dn_ready;
    assign take       = i_up_valid && o_up_ready;
    assign o_dn_valid = r_valid;
    assign o_dn       = r_beat;

    always_comb begin
        // fold an out-of-range start back by one wheel turn
        start_red = (i_start >= SZ) ? (i_start - SZ) : i_start;
        pos       = i_up.restart ? start_red : r_pos;
        n_pos     = (pos == LAST) ? '0 : (pos + 1'b1);
        n_beat    = i_up;
        if (i_pin_mask[pos]) begin
            n_beat.sum = i_up.sum + {{(SUM_W-LUG_W){1'b0}}, i_lug};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pos   <= '0;
        end else begin
            if (o_up_ready) begin
                r_valid <= i_up_valid;
            end
            if (take) begin
                r_pos <= n_pos;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_beat <= n_beat;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/pwl_fold.sv -----
`default_nettype none

module pwl_fold (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    input  pwl_pkg::t_beat                     i_beat,
    output logic                               o_ready,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [pwl_pkg::LETTER_W-1:0]       o_cipher_letter,
    output logic [pwl_pkg::SUM_W-1:0]          o_keystream_sum,
    output logic [pwl_pkg::LETTER_W-1:0]       o_key_letter
);
    import pwl_pkg::*;

    // floor(x / 26) ~ (x * 79) >> 11, then one correcting subtract
    localparam logic [6:0] RECIP = 7'd79;

    logic                 r_valid;
    logic [LETTER_W-1:0]  r_cipher;
    logic [SUM_W-1:0]     r_sum;
    logic [LETTER_W-1:0]  r_key;

    logic [14:0]          prod;
    logic [2:0]           quot;
    logic [SUM_W-1:0]     rem;
    logic [LETTER_W-1:0]  n_key;
    logic [LETTER_W-1:0]  let_red;
    logic [LETTER_W:0]    diff;
    logic [LETTER_W-1:0]  n_cipher;

    assign o_ready = !r_valid || !i_stall;

    always_comb begin
        prod  = {7'd0, i_beat.sum} * {8'd0, RECIP};
        quot  = prod[13:11];
        rem   = i_beat.sum - ({1'b0, quot, 4'd0} + {2'd0, quot, 3'd0} + {4'd0, quot, 1'b0});
        if (rem >= SUM_W'(ALPHA)) begin
            rem = rem - SUM_W'(ALPHA);
        end
        n_key   = rem[LETTER_W-1:0];
        let_red = (i_beat.letter >= ALPHA) ? (i_beat.letter - ALPHA) : i_beat.letter;
        diff    = {1'b0, n_key} - {1'b0, let_red};
        if (diff[LETTER_W]) begin
            diff = diff + {1'b0, ALPHA};
        end
        n_cipher = diff[LETTER_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_cipher <= n_cipher;
            r_sum    <= i_beat.sum;
            r_key    <= n_key;
        end
    end

    assign o_valid         = r_valid;
    assign o_cipher_letter = r_cipher;
    assign o_keystream_sum = r_sum;
    assign o_key_letter    = r_key;

endmodule

`default_nettype wire

// ----- hw/rtl/pwl_checker.sv -----
`default_nettype none

module pwl_checker (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            o_valid,
    input  wire logic                            i_stall,
    input  wire logic [pwl_pkg::LETTER_W-1:0]    o_cipher_letter,
    input  wire logic [pwl_pkg::SUM_W-1:0]       o_keystream_sum,
    input  wire logic [pwl_pkg::LETTER_W-1:0]    o_key_letter
);

    // hold a stalled result beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_cipher_letter)
            && $stable(o_keystream_sum) && $stable(o_key_letter))
        else $error("result beat changed under stall");

    // reset drops any result in flight
    a_reset_drop: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // letters always land in the alphabet
    a_letters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_key_letter <= 5'd25) && (o_cipher_letter <= 5'd25))
        else $error("letter out of range");

    // six lug counts of at most 31 bound the sum
    a_sum_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_keystream_sum <= 8'd186)
        else $error("keystream sum out of range");

endmodule

bind pin_wheel_lug_cipher_core pwl_checker u_pwl_checker (.*);

`default_nettype wire
